@@ sv/lzd_pkg.sv @@
// Shared constants and types for the LZ bitstream decompressor.
// Depends on nothing; imported by the top level.
package lzd_pkg;

	localparam int HISTORY_DEPTH_DEF   = 65536;
	localparam int MAX_BLOCK_BYTES_DEF = 65536;

	// Decode table: 4 one-byte, 8 length, 8 two-byte and up to 31 long offset slots.
	localparam int TBL_DEPTH = 51;
	localparam int TBL_AW    = 6;
	localparam int TBL_BW    = 20;
	localparam int TBL_W     = TBL_BW + 4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TRUNC    = 3'd1;
	localparam logic [2:0] ST_BLOCK    = 3'd2;
	localparam logic [2:0] ST_OFFSET   = 3'd3;
	localparam logic [2:0] ST_LENGTH   = 3'd4;
	localparam logic [2:0] ST_TRAILING = 3'd5;

	typedef enum logic [4:0] {
		PH_HDR, PH_TBL, PH_CODE, PH_PREFIX, PH_LIT, PH_RUNLEN, PH_RUN,
		PH_LEN_RD, PH_LEN_LD, PH_LEN, PH_OSEL1, PH_OSEL2, PH_OSEL3,
		PH_SEL_RD, PH_SEL_LD, PH_OFF, PH_SHORT, PH_DELTA, PH_COPY,
		PH_COPY_WR, PH_DONE
	} phase_t;

endpackage

@@ sv/lz_bitstream_decompressor.sv @@
// Top level of the LZ bitstream decompressor: decode sequencer, result register.
// Depends on lzd_pkg and lzd_ram (history window and decode table).
//
// Usage. Each word on the input channel (in_valid/in_stall) is either a
// compressed byte (mode 0, with in_last on the final byte) or a request to
// move on to the next decompressed byte (mode 1). Every accepted word gives
// exactly one result word on the output channel (res_valid/res_stall) that
// carries out_valid/out_byte, need_byte, finished and status.
// After a word is accepted the sequencer runs until it needs another
// compressed byte, shows a new output byte, finishes or hits an error.
// Compressed bits are shifted out one per cycle while the bit shift register
// holds bits, and a new byte is loaded into it when it is empty. Each decode
// table lookup takes a read step and a load step (synchronous table RAM), and
// each copied byte takes a history RAM read step, then a write step.
// One word is in work at a time; the next is taken once the result
// register is free or is being emptied in the same cycle.
// While the receiver stalls, the result is held and in_stall stays high.
// Reset clears all control state and starts by reading block tables; the
// history and table RAMs need no clearing, since every entry is written
// before it is read.
module lz_bitstream_decompressor #(
	parameter int HISTORY_DEPTH   = lzd_pkg::HISTORY_DEPTH_DEF,
	parameter int MAX_BLOCK_BYTES = lzd_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       need_byte,
	output logic       finished,
	output logic [2:0] status
);

	import lzd_pkg::*;

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int WW  = $clog2(HISTORY_DEPTH + 1);
	localparam int VW  = WW + 1;
	localparam int BBW = $clog2(MAX_BLOCK_BYTES + 2);
	localparam int CW  = ((WW > 21) ? WW : 21) + 1;

	// Sequencer state.
	phase_t            phase_q, phase_d;
	logic              busy_q, busy_d;
	logic [2:0]        err_q, err_d;
	logic              out_full_q, out_full_d;
	logic [7:0]        out_reg_q, out_reg_d;
	logic              in_full_q, in_full_d;
	logic [7:0]        in_reg_q, in_reg_d;
	logic              stream_end_q, stream_end_d;
	logic [7:0]        shift_q, shift_d;
	logic [3:0]        bits_left_q, bits_left_d;
	logic [14:0]       acc_q, acc_d;
	logic [3:0]        cnt_q, cnt_d;
	logic [2:0]        p_q, p_d;
	logic [3:0]        n_q, n_d;
	logic [TBL_AW-1:0] tbl_i_q, tbl_i_d;
	logic [20:0]       sum_q, sum_d;
	logic [TBL_AW-1:0] sel_q, sel_d;
	logic [TBL_BW-1:0] base_q, base_d;
	logic [20:0]       off_q, off_d;
	logic [WW-1:0]     cd_q, cd_d;
	logic [7:0]        delta_q, delta_d;
	logic [15:0]       run_q, run_d;
	logic [AW-1:0]     wp_q, wp_d;
	logic [WW-1:0]     written_q, written_d;
	logic [BBW-1:0]    bb_q, bb_d;

	// Result register.
	logic       res_valid_q, res_valid_d;
	logic       r_ov_q, r_need_q, r_fin_q;
	logic [7:0] r_byte_q;
	logic [2:0] r_st_q;
	logic       res_load, ld_ov, ld_need, ld_fin;
	logic [7:0] ld_byte;
	logic [2:0] ld_st;

	// Memory ports.
	logic              hist_we;
	logic [7:0]        hist_wdata, hist_rdata;
	logic [AW-1:0]     hist_raddr;
	logic              tbl_we;
	logic [TBL_W-1:0]  tbl_wdata, tbl_rdata;

	// Helpers.
	logic              in_acc, halt, starve, do_emit, do_copy, pull_ph;
	logic [7:0]        emit_b;
	logic [20:0]       copy_off;
	logic              cur_ov, cur_need;
	logic [VW-1:0]     wp_ext, cd_ext, cv;
	logic [6:0]        tbl_next, tbl_lim;
	logic [20:0]       sum_base;
	logic [21:0]       len_v;
	logic [TBL_AW-1:0] long_sel;
	logic [3:0]        n_inc;

	lzd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_q),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	lzd_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_i_q),
		.wdata (tbl_wdata),
		.raddr (sel_q),
		.rdata (tbl_rdata)
	);

	assign in_stall = busy_q || (res_valid_q && res_stall);
	assign in_acc   = in_valid && !in_stall;

	assign cur_ov   = out_full_q && (err_q == ST_OK);
	assign cur_need = (err_q == ST_OK) && (phase_q != PH_DONE) && !out_full_q;
	assign halt     = (err_q != ST_OK) || (phase_q == PH_DONE) || out_full_q;

	// Source address of the next copied byte, wrapped into the window.
	assign wp_ext     = VW'(wp_q);
	assign cd_ext     = VW'(cd_q);
	assign cv         = (wp_ext >= cd_ext) ? (wp_ext - cd_ext)
	                                       : (wp_ext + VW'(HISTORY_DEPTH) - cd_ext);
	assign hist_raddr = cv[AW-1:0];

	assign tbl_next = 7'(tbl_i_q) + 7'd1;
	assign tbl_lim  = 7'd19 + (7'd1 << p_q);
	assign sum_base = (tbl_i_q == TBL_AW'(0) || tbl_i_q == TBL_AW'(4) ||
	                   tbl_i_q == TBL_AW'(12) || tbl_i_q == TBL_AW'(20)) ? 21'd0 : sum_q;
	assign len_v    = 22'(base_q) + 22'(acc_q) + 22'd1;
	assign long_sel = (TBL_AW'(acc_q[4:0]) + TBL_AW'(19) > TBL_AW'(TBL_DEPTH - 1))
	                  ? TBL_AW'(TBL_DEPTH - 1) : TBL_AW'(acc_q[4:0]) + TBL_AW'(19);
	assign n_inc    = n_q + 4'd1;

	assign pull_ph = (phase_q == PH_HDR) || (phase_q == PH_TBL) || (phase_q == PH_PREFIX) ||
	                 (phase_q == PH_LEN) || (phase_q == PH_OSEL1) || (phase_q == PH_OSEL2) ||
	                 (phase_q == PH_OSEL3) || (phase_q == PH_OFF) || (phase_q == PH_SHORT);

	// Next-state logic of the sequencer.
	always_comb begin
		phase_d      = phase_q;
		busy_d       = busy_q;
		err_d        = err_q;
		out_full_d   = out_full_q;
		out_reg_d    = out_reg_q;
		in_full_d    = in_full_q;
		in_reg_d     = in_reg_q;
		stream_end_d = stream_end_q;
		shift_d      = shift_q;
		bits_left_d  = bits_left_q;
		acc_d        = acc_q;
		cnt_d        = cnt_q;
		p_d          = p_q;
		n_d          = n_q;
		tbl_i_d      = tbl_i_q;
		sum_d        = sum_q;
		sel_d        = sel_q;
		base_d       = base_q;
		off_d        = off_q;
		cd_d         = cd_q;
		delta_d      = delta_q;
		run_d        = run_q;
		wp_d         = wp_q;
		written_d    = written_q;
		bb_d         = bb_q;
		res_load     = 1'b0;
		ld_ov        = cur_ov;
		ld_byte      = cur_ov ? out_reg_q : 8'd0;
		ld_need      = cur_need;
		ld_fin       = (phase_q == PH_DONE);
		ld_st        = err_q;
		starve       = 1'b0;
		do_emit      = 1'b0;
		emit_b       = in_reg_q;
		do_copy      = 1'b0;
		copy_off     = off_q;
		tbl_we       = 1'b0;
		tbl_wdata    = {acc_q[3:0], sum_base[TBL_BW-1:0]};

		if (!busy_q) begin
			if (in_acc) begin
				if (!mode) begin
					if (cur_need) begin
						in_full_d    = 1'b1;
						in_reg_d     = in_byte;
						stream_end_d = stream_end_q | in_last;
						busy_d       = 1'b1;
					end else begin
						res_load = 1'b1;
					end
				end else if (cur_ov) begin
					out_full_d = 1'b0;
					busy_d     = 1'b1;
				end else begin
					res_load = 1'b1;
				end
			end
		end else if (halt) begin
			busy_d   = 1'b0;
			res_load = 1'b1;
		end else if (pull_ph && cnt_q != 4'd0) begin
			// One field bit per cycle, or a byte load when the shifter is empty.
			if (bits_left_q == 4'd0) begin
				if (in_full_q) begin
					shift_d     = in_reg_q;
					bits_left_d = 4'd8;
					in_full_d   = 1'b0;
				end else begin
					starve = 1'b1;
				end
			end else begin
				acc_d       = {acc_q[13:0], shift_q[7]};
				shift_d     = {shift_q[6:0], 1'b0};
				bits_left_d = bits_left_q - 4'd1;
				cnt_d       = cnt_q - 4'd1;
			end
		end else begin
			case (phase_q)
				PH_HDR: begin
					p_d     = 3'(acc_q[1:0]) + 3'd2;
					tbl_i_d = '0;
					sum_d   = '0;
					acc_d   = '0;
					cnt_d   = 4'd4;
					phase_d = PH_TBL;
				end
				PH_TBL: begin
					tbl_we  = 1'b1;
					sum_d   = sum_base + (21'd1 << acc_q[3:0]);
					tbl_i_d = tbl_next[TBL_AW-1:0];
					acc_d   = '0;
					if (tbl_next >= tbl_lim || tbl_next >= 7'(TBL_DEPTH)) begin
						bb_d    = '0;
						phase_d = PH_CODE;
					end else begin
						cnt_d = 4'd4;
					end
				end
				PH_CODE: begin
					if (bb_q > BBW'(MAX_BLOCK_BYTES)) begin
						err_d = ST_BLOCK;
					end else begin
						n_d     = '0;
						acc_d   = '0;
						cnt_d   = 4'd1;
						phase_d = PH_PREFIX;
					end
				end
				PH_PREFIX: begin
					if (acc_q[0]) begin
						n_d = n_inc;
						if (n_inc < 4'd9) begin
							acc_d = '0;
							cnt_d = 4'd1;
						end else begin
							phase_d = PH_RUNLEN;
						end
					end else if (n_q == 4'd0) begin
						phase_d = PH_LIT;
					end else begin
						sel_d   = TBL_AW'(n_q) + TBL_AW'(3);
						phase_d = PH_LEN_RD;
					end
				end
				PH_LIT: begin
					if (in_full_q) begin
						in_full_d = 1'b0;
						do_emit   = 1'b1;
						phase_d   = PH_CODE;
					end else begin
						starve = 1'b1;
					end
				end
				PH_RUNLEN: begin
					if (in_full_q) begin
						in_full_d = 1'b0;
						if (in_reg_q == 8'd0) begin
							phase_d = PH_DONE;
							if (!stream_end_q || shift_q != 8'd0) begin
								err_d = ST_TRAILING;
							end
						end else if (in_reg_q == 8'd1) begin
							acc_d   = '0;
							cnt_d   = 4'd2;
							phase_d = PH_HDR;
						end else begin
							run_d   = 16'(in_reg_q) + 16'd16;
							phase_d = PH_RUN;
						end
					end else begin
						starve = 1'b1;
					end
				end
				PH_RUN: begin
					if (in_full_q) begin
						in_full_d = 1'b0;
						do_emit   = 1'b1;
						run_d     = run_q - 16'd1;
						if (run_q == 16'd1) begin
							phase_d = PH_CODE;
						end
					end else begin
						starve = 1'b1;
					end
				end
				PH_LEN_RD: begin
					phase_d = PH_LEN_LD;
				end
				PH_LEN_LD: begin
					base_d  = tbl_rdata[TBL_BW-1:0];
					acc_d   = '0;
					cnt_d   = tbl_rdata[TBL_W-1:TBL_BW];
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					if (len_v > 22'd65535) begin
						err_d = ST_LENGTH;
					end else begin
						run_d = len_v[15:0];
						acc_d = '0;
						if (len_v == 22'd1) begin
							cnt_d   = 4'd2;
							phase_d = PH_OSEL1;
						end else if (len_v == 22'd2) begin
							cnt_d   = 4'd3;
							phase_d = PH_OSEL2;
						end else begin
							cnt_d   = 4'(p_q);
							phase_d = PH_OSEL3;
						end
					end
				end
				PH_OSEL1: begin
					sel_d   = TBL_AW'(acc_q[1:0]);
					phase_d = PH_SEL_RD;
				end
				PH_OSEL2: begin
					sel_d   = TBL_AW'(acc_q[2:0]) + TBL_AW'(12);
					phase_d = PH_SEL_RD;
				end
				PH_OSEL3: begin
					if (acc_q[4:0] == 5'd0) begin
						acc_d   = '0;
						cnt_d   = 4'd5;
						phase_d = PH_SHORT;
					end else begin
						sel_d   = long_sel;
						phase_d = PH_SEL_RD;
					end
				end
				PH_SEL_RD: begin
					phase_d = PH_SEL_LD;
				end
				PH_SEL_LD: begin
					base_d  = tbl_rdata[TBL_BW-1:0];
					acc_d   = '0;
					cnt_d   = tbl_rdata[TBL_W-1:TBL_BW];
					phase_d = PH_OFF;
				end
				PH_OFF: begin
					delta_d  = 8'd0;
					do_copy  = 1'b1;
					copy_off = 21'(base_q) + 21'(acc_q);
				end
				PH_SHORT: begin
					off_d   = 21'(5'd31 - acc_q[4:0]);
					phase_d = PH_DELTA;
				end
				PH_DELTA: begin
					if (in_full_q) begin
						in_full_d = 1'b0;
						delta_d   = in_reg_q;
						do_copy   = 1'b1;
					end else begin
						starve = 1'b1;
					end
				end
				PH_COPY: begin
					phase_d = PH_COPY_WR;
				end
				PH_COPY_WR: begin
					do_emit = 1'b1;
					emit_b  = hist_rdata + delta_q;
					run_d   = run_q - 16'd1;
					phase_d = (run_q == 16'd1) ? PH_CODE : PH_COPY;
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end

		// A byte was needed but none is buffered: report and wait, or flag truncation after the last byte.
		if (starve) begin
			busy_d   = 1'b0;
			res_load = 1'b1;
			ld_ov    = 1'b0;
			ld_byte  = 8'd0;
			ld_need  = !stream_end_q;
			ld_fin   = 1'b0;
			ld_st    = stream_end_q ? ST_TRUNC : ST_OK;
			if (stream_end_q) begin
				err_d = ST_TRUNC;
			end
		end

		if (do_copy) begin
			if (CW'(copy_off) >= CW'(written_q)) begin
				err_d = ST_OFFSET;
			end else begin
				cd_d    = WW'(copy_off + 21'd1);
				phase_d = PH_COPY;
			end
		end

		if (do_emit) begin
			wp_d       = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			written_d  = (written_q < WW'(HISTORY_DEPTH)) ? written_q + WW'(1) : written_q;
			bb_d       = (bb_q <= BBW'(MAX_BLOCK_BYTES)) ? bb_q + BBW'(1) : bb_q;
			out_full_d = 1'b1;
			out_reg_d  = emit_b;
		end

		res_valid_d = res_valid_q && res_stall;
		if (res_load) begin
			res_valid_d = 1'b1;
		end
	end

	assign hist_we    = do_emit;
	assign hist_wdata = emit_b;

	// Output ports come straight from the result register.
	always_comb begin
		res_valid = res_valid_q;
		out_valid = r_ov_q;
		out_byte  = r_byte_q;
		need_byte = r_need_q;
		finished  = r_fin_q;
		status    = r_st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR;
			busy_q       <= 1'b0;
			err_q        <= ST_OK;
			out_full_q   <= 1'b0;
			in_full_q    <= 1'b0;
			stream_end_q <= 1'b0;
			shift_q      <= '0;
			bits_left_q  <= '0;
			acc_q        <= '0;
			cnt_q        <= 4'd2;
			p_q          <= 3'd2;
			n_q          <= '0;
			tbl_i_q      <= '0;
			sum_q        <= '0;
			run_q        <= '0;
			wp_q         <= '0;
			written_q    <= '0;
			bb_q         <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			busy_q       <= busy_d;
			err_q        <= err_d;
			out_full_q   <= out_full_d;
			in_full_q    <= in_full_d;
			stream_end_q <= stream_end_d;
			shift_q      <= shift_d;
			bits_left_q  <= bits_left_d;
			acc_q        <= acc_d;
			cnt_q        <= cnt_d;
			p_q          <= p_d;
			n_q          <= n_d;
			tbl_i_q      <= tbl_i_d;
			sum_q        <= sum_d;
			run_q        <= run_d;
			wp_q         <= wp_d;
			written_q    <= written_d;
			bb_q         <= bb_d;
			res_valid_q  <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_reg_q <= out_reg_d;
		in_reg_q  <= in_reg_d;
		sel_q     <= sel_d;
		base_q    <= base_d;
		off_q     <= off_d;
		cd_q      <= cd_d;
		delta_q   <= delta_d;
		if (res_load) begin
			r_ov_q   <= ld_ov;
			r_byte_q <= ld_byte;
			r_need_q <= ld_need;
			r_fin_q  <= ld_fin;
			r_st_q   <= ld_st;
		end
	end

	// An error code never changes once set.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) |=> (err_q == $past(err_q)))
		else $error("error code changed after being set");

	// A result never shows a byte and a byte request together.
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(r_ov_q && r_need_q))
		else $error("result shows a byte and requests one");

	// A history read is always followed by the write-back step.
	a_copy_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !halt && phase_q == PH_COPY) |=> (phase_q == PH_COPY_WR))
		else $error("copy read not followed by write-back");

	// Only one word is in work: none is taken while the sequencer runs.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && busy_d) |=> !in_acc)
		else $error("word accepted while decoding");

endmodule

@@ sv/lzd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ test/lz_bitstream_decompressor_tb.sv @@
// Testbench for the LZ bitstream decompressor: encodes a random stream, which may end in an error,
// predicts every result word and checks the block's output words against them.
// Depends on lzd_pkg and lz_bitstream_decompressor.
`timescale 1ns / 100ps

module lz_bitstream_decompressor_tb;
	import lzd_pkg::*;

	localparam int WIN       = HISTORY_DEPTH_DEF;
	localparam int BLK_MAX   = MAX_BLOCK_BYTES_DEF;
	localparam int TBL_N     = TBL_DEPTH;
	localparam int LIMIT     = 400000;
	localparam int OUT_GOAL  = 220;
	localparam int CALM_TAIL = 60;

	// Kinds of code the stream encoder can be told to write.
	localparam int K_RANDOM = -1;
	localparam int K_LIT    = 0;
	localparam int K_RUN    = 1;
	localparam int K_ONE    = 2;
	localparam int K_TWO    = 3;
	localparam int K_LONG   = 4;
	localparam int K_SHORT  = 5;
	localparam int K_MATCH  = 6;

	// Table sets the encoder can put at the head of a block.
	localparam int TS_RANDOM = 0;
	localparam int TS_FIXED  = 1;
	localparam int TS_ERROR  = 2;

	// Ways the stream can end.
	localparam int END_CLEAN = 0;
	localparam int END_TRAIL = 1;
	localparam int END_TRUNC = 2;
	localparam int END_OFFS  = 3;
	localparam int END_LEN   = 4;

	typedef struct packed {
		logic       mode;
		logic [7:0] data;
		logic       last;
	} word_t;

	typedef struct packed {
		logic       ov;
		logic [7:0] ob;
		logic       nb;
		logic       fin;
		logic [2:0] st;
	} res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       mode = 1'b0;
	logic [7:0] in_byte = 8'd0;
	logic       in_last = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       need_byte;
	logic       finished;
	logic [2:0] status;

	lz_bitstream_decompressor DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .in_byte(in_byte), .in_last(in_last),
		.res_valid(res_valid), .res_stall(res_stall),
		.out_valid(out_valid), .out_byte(out_byte), .need_byte(need_byte),
		.finished(finished), .status(status)
	);

	always #1 clk = ~clk;

	// Words still to be sent, with the result each one is predicted to give.
	word_t word_q[$];
	res_t  word_res_q[$];
	// Results of accepted words that have not come out yet.
	res_t  due_q[$];
	res_t  cur_res;
	logic  took = 1'b0;
	bit    go = 1'b0;
	int    n_words, n_taken, errors, cycles;
	int    send_gap, recv_hold;
	bit    pressed;

	// ------------------------------------------------------------------
	// Decoder predictor. It follows the block bit for bit: a bit reader
	// that shifts MSB first, literal bytes taken whole from the stream,
	// the decode tables and the history window.
	// ------------------------------------------------------------------
	bit [7:0]    dec_hist [WIN];
	bit [3:0]    dec_w [TBL_N];
	int unsigned dec_base [TBL_N];
	int unsigned dec_pbits, dec_left, dec_run, dec_dist, dec_wp, dec_blk, dec_written;
	int unsigned dec_acc, dec_cnt, dec_pre, dec_ti, dec_tsum, dec_sel;
	bit [7:0]    dec_shift, dec_delta, dec_in, dec_out;
	bit [2:0]    dec_err;
	bit          dec_in_full, dec_end, dec_out_full;
	phase_t      dec_ph;

	function automatic void dec_field(int unsigned n, phase_t nxt);
		dec_acc = 0;
		dec_cnt = n;
		dec_ph = nxt;
	endfunction

	function automatic void dec_reset();
		dec_pbits = 2;
		dec_shift = 0;
		dec_left = 0;
		dec_run = 0;
		dec_dist = 0;
		dec_delta = 0;
		dec_wp = 0;
		dec_blk = 0;
		dec_err = ST_OK;
		dec_written = 0;
		dec_pre = 0;
		dec_ti = 0;
		dec_tsum = 0;
		dec_sel = 0;
		dec_in_full = 0;
		dec_in = 0;
		dec_end = 0;
		dec_out_full = 0;
		dec_out = 0;
		dec_field(2, PH_HDR);
	endfunction

	// Takes the offered byte; with none left after the last one, the stream is truncated.
	function automatic bit dec_take(output bit [7:0] b);
		b = dec_in;
		if (dec_in_full) begin
			dec_in_full = 0;
			return 1;
		end
		if (dec_end)
			dec_err = ST_TRUNC;
		return 0;
	endfunction

	function automatic bit dec_pull();
		bit [7:0] b;
		while (dec_cnt > 0) begin
			if (dec_left == 0) begin
				if (!dec_take(b))
					return 0;
				dec_shift = b;
				dec_left = 8;
			end
			dec_acc = (dec_acc << 1) | dec_shift[7];
			dec_shift = dec_shift << 1;
			dec_left--;
			dec_cnt--;
		end
		return 1;
	endfunction

	function automatic void dec_emit(bit [7:0] b);
		dec_hist[dec_wp] = b;
		dec_wp = (dec_wp + 1 >= WIN) ? 0 : dec_wp + 1;
		if (dec_written < WIN)
			dec_written++;
		if (dec_blk <= BLK_MAX)
			dec_blk++;
		dec_out_full = 1;
		dec_out = b;
	endfunction

	function automatic void dec_set_copy(int unsigned off);
		if (off >= dec_written) begin
			dec_err = ST_OFFSET;
		end else begin
			dec_dist = off + 1;
			dec_ph = PH_COPY;
		end
	endfunction

	// Runs the decoder until it waits for a byte, shows a byte, ends or fails.
	function automatic void dec_advance();
		bit [7:0]    b;
		int unsigned v;
		while (dec_err == ST_OK && dec_ph != PH_DONE && !dec_out_full) begin
			case (dec_ph)
				PH_HDR: begin
					if (!dec_pull())
						return;
					dec_pbits = dec_acc + 2;
					dec_ti = 0;
					dec_tsum = 0;
					dec_field(4, PH_TBL);
				end
				PH_TBL: begin
					if (!dec_pull())
						return;
					if (dec_ti == 0 || dec_ti == 4 || dec_ti == 12 || dec_ti == 20)
						dec_tsum = 0;
					dec_w[dec_ti] = dec_acc[3:0];
					dec_base[dec_ti] = dec_tsum;
					dec_tsum += 1 << dec_acc;
					dec_ti++;
					if (dec_ti >= 20 + (1 << dec_pbits) - 1 || dec_ti >= TBL_N) begin
						dec_blk = 0;
						dec_ph = PH_CODE;
					end else begin
						dec_field(4, PH_TBL);
					end
				end
				PH_CODE: begin
					if (dec_blk > BLK_MAX) begin
						dec_err = ST_BLOCK;
					end else begin
						dec_pre = 0;
						dec_field(1, PH_PREFIX);
					end
				end
				PH_PREFIX: begin
					if (!dec_pull())
						return;
					if (dec_acc != 0)
						dec_pre++;
					if (dec_acc != 0 && dec_pre < 9)
						dec_field(1, PH_PREFIX);
					else if (dec_pre == 0)
						dec_ph = PH_LIT;
					else if (dec_pre == 9)
						dec_ph = PH_RUNLEN;
					else
						dec_field(dec_w[3 + dec_pre], PH_LEN);
				end
				PH_LIT: begin
					if (!dec_take(b))
						return;
					dec_emit(b);
					dec_ph = PH_CODE;
				end
				PH_RUNLEN: begin
					if (!dec_take(b))
						return;
					if (b == 0) begin
						dec_ph = PH_DONE;
						if (!dec_end || dec_shift != 0)
							dec_err = ST_TRAILING;
					end else if (b == 1) begin
						dec_field(2, PH_HDR);
					end else begin
						dec_run = b + 16;
						dec_ph = PH_RUN;
					end
				end
				PH_RUN: begin
					if (!dec_take(b))
						return;
					dec_emit(b);
					dec_run--;
					if (dec_run == 0)
						dec_ph = PH_CODE;
				end
				PH_LEN: begin
					if (!dec_pull())
						return;
					v = dec_base[3 + dec_pre] + dec_acc + 1;
					if (v > 65535) begin
						dec_err = ST_LENGTH;
					end else begin
						dec_run = v;
						if (v == 1)
							dec_field(2, PH_OSEL1);
						else if (v == 2)
							dec_field(3, PH_OSEL2);
						else
							dec_field(dec_pbits, PH_OSEL3);
					end
				end
				PH_OSEL1, PH_OSEL2: begin
					if (!dec_pull())
						return;
					dec_sel = (dec_ph == PH_OSEL1) ? dec_acc : 12 + dec_acc;
					dec_field(dec_w[dec_sel], PH_OFF);
				end
				PH_OSEL3: begin
					if (!dec_pull())
						return;
					if (dec_acc == 0) begin
						dec_field(5, PH_SHORT);
					end else begin
						dec_sel = 20 + dec_acc - 1;
						if (dec_sel >= TBL_N)
							dec_sel = TBL_N - 1;
						dec_field(dec_w[dec_sel], PH_OFF);
					end
				end
				PH_OFF: begin
					if (!dec_pull())
						return;
					dec_delta = 0;
					dec_set_copy(dec_base[dec_sel] + dec_acc);
				end
				PH_SHORT: begin
					if (!dec_pull())
						return;
					dec_dist = 31 - (dec_acc & 31);
					dec_ph = PH_DELTA;
				end
				PH_DELTA: begin
					if (!dec_take(b))
						return;
					dec_delta = b;
					dec_set_copy(dec_dist);
				end
				PH_COPY: begin
					v = (dec_wp >= dec_dist) ? dec_wp - dec_dist : dec_wp + WIN - dec_dist;
					if (v >= WIN)
						v = 0;
					b = dec_hist[v] + dec_delta;
					dec_emit(b);
					dec_run--;
					if (dec_run == 0)
						dec_ph = PH_CODE;
				end
				default: dec_ph = PH_DONE;
			endcase
		end
	endfunction

	// One word in, one result word out.
	function automatic res_t dec_word(bit m, bit [7:0] b, bit last);
		res_t r;
		bit   waiting;
		waiting = dec_err == ST_OK && dec_ph != PH_DONE && !dec_out_full;
		if (!m) begin
			if (waiting) begin
				dec_in_full = 1;
				dec_in = b;
				if (last)
					dec_end = 1;
				dec_advance();
			end
		end else if (dec_out_full && dec_err == ST_OK) begin
			dec_out_full = 0;
			dec_advance();
		end
		r.ov = dec_out_full && dec_err == ST_OK;
		r.ob = r.ov ? dec_out : 8'd0;
		r.nb = dec_err == ST_OK && dec_ph != PH_DONE && !dec_out_full;
		r.fin = dec_ph == PH_DONE;
		r.st = dec_err;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stream encoder. Bits go MSB first into a byte that is placed in the
	// stream when its first bit is written, and literal bytes are appended
	// whole, which is the order in which the decoder pulls them.
	// ------------------------------------------------------------------
	bit [7:0]    comp_bytes[$];
	int          bit_at, bits_free;
	int unsigned enc_total, enc_p;
	int unsigned enc_w [TBL_N];
	int unsigned enc_base [TBL_N];

	task automatic enc_bits(int unsigned val, int n);
		for (int i = n - 1; i >= 0; i--) begin
			if (bits_free == 0) begin
				comp_bytes.push_back(8'd0);
				bit_at = comp_bytes.size() - 1;
				bits_free = 8;
			end
			comp_bytes[bit_at][bits_free - 1] = val[i];
			bits_free--;
		end
	endtask

	task automatic enc_lit(bit [7:0] b);
		enc_bits(0, 1);
		comp_bytes.push_back(b);
		enc_total++;
	endtask

	// Writes the block header: prefix size, then the widths, and notes their running bases.
	task automatic enc_tables(int set, int unsigned p);
		int unsigned n, sum;
		n = 20 + (1 << p) - 1;
		enc_p = p;
		enc_bits(p - 2, 2);
		sum = 0;
		for (int i = 0; i < n; i++) begin
			if (i == 0 || i == 4 || i == 12 || i == 20)
				sum = 0;
			case (set)
				TS_FIXED:
					enc_w[i] = (i < 4) ? i + (i == 3) : (i == 4) ? 2 :
						(i < 12) ? 1 : (i < 20) ? 1 : (i == 20) ? 0 : (i == 21) ? 3 : 8;
				TS_ERROR:
					enc_w[i] = (i == 4) ? 2 : (i == 5 || i == 6 || i == 20) ? 15 : 0;
				default:
					enc_w[i] = (i < 4) ? $urandom_range(0, 4) : (i < 12) ? $urandom_range(0, 3) :
						(i < 20) ? $urandom_range(0, 4) : $urandom_range(0, 8);
			endcase
			enc_base[i] = sum;
			sum += 1 << enc_w[i];
			enc_bits(enc_w[i], 4);
		end
	endtask

	task automatic enc_new_block(int set, int unsigned p);
		enc_bits(9'h1FF, 9);
		comp_bytes.push_back(8'd1);
		enc_tables(set, p);
	endtask

	// Writes one code. Matches pick an offset inside the data written so far;
	// when a few tries find none, a literal goes in instead.
	task automatic enc_code(int kind);
		int unsigned n, f, len, s, sel, f2, off, v;
		bit [7:0]    dl;
		bit          ok;
		if (kind == K_RANDOM) begin
			v = $urandom_range(0, 9);
			kind = (v < 3) ? K_LIT : (v == 3) ? K_RUN : K_MATCH;
		end
		if (kind == K_LIT) begin
			enc_lit($urandom_range(0, 255));
		end else if (kind == K_RUN) begin
			n = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(2, 12);
			enc_bits(9'h1FF, 9);
			comp_bytes.push_back(n);
			repeat (n + 16)
				comp_bytes.push_back($urandom_range(0, 255));
			enc_total += n + 16;
		end else begin
			ok = 0;
			for (int t = 0; t < 8 && !ok; t++) begin
				n = (kind == K_ONE || kind == K_TWO) ? 1 : $urandom_range(1, 8);
				f = (kind == K_ONE) ? 0 : (kind == K_TWO) ? 1 :
					$urandom_range(0, (1 << enc_w[3 + n]) - 1);
				len = enc_base[3 + n] + f + 1;
				s = 0;
				sel = 0;
				if (len == 1)
					sel = $urandom_range(0, 3);
				else if (len == 2)
					sel = 12 + $urandom_range(0, 7);
				else begin
					s = (kind == K_LONG) ? $urandom_range(1, (1 << enc_p) - 1) :
						(kind == K_SHORT) ? 0 : $urandom_range(0, (1 << enc_p) - 1);
					sel = 20 + s - 1;
				end
				if (len >= 3 && s == 0) begin
					v = $urandom_range(0, 31);
					off = 31 - v;
				end else begin
					f2 = $urandom_range(0, (1 << enc_w[sel]) - 1);
					off = enc_base[sel] + f2;
				end
				ok = off < enc_total;
			end
			if (!ok) begin
				enc_lit($urandom_range(0, 255));
			end else begin
				enc_bits(((1 << n) - 1) << 1, n + 1);
				enc_bits(f, enc_w[3 + n]);
				if (len == 1)
					enc_bits(sel, 2);
				else if (len == 2)
					enc_bits(sel - 12, 3);
				else
					enc_bits(s, enc_p);
				if (len >= 3 && s == 0) begin
					dl = (kind == K_SHORT) ? 8'hFF : $urandom_range(0, 255);
					enc_bits(v, 5);
					comp_bytes.push_back(dl);
				end else begin
					enc_bits(f2, enc_w[sel]);
				end
				enc_total += len;
			end
		end
	endtask

	task automatic add_word(bit m, bit [7:0] b, bit last);
		word_q.push_back('{mode: m, data: b, last: last});
		word_res_q.push_back(dec_word(m, b, last));
	endtask

	// Builds the whole compressed stream, then turns it into words by asking
	// the predictor what the decoder waits for at each point.
	task automatic build_stimulus();
		int          ending, idx;
		bit          mark_last;
		bit [7:0]    kinds [$];
		dec_reset();
		bits_free = 0;
		enc_total = 0;

		// Opening block with fixed tables: byte extremes and every code kind.
		enc_tables(TS_FIXED, 2);
		enc_lit(8'h00);
		enc_lit(8'hFF);
		enc_lit(8'h5A);
		enc_lit(8'hA5);
		kinds = '{K_RUN, K_ONE, K_TWO, K_LONG, K_SHORT, K_LONG, K_ONE};
		foreach (kinds[i])
			enc_code(kinds[i]);

		// Random blocks; the first has the largest prefix size.
		for (int blk = 0; enc_total < OUT_GOAL; blk++) begin
			enc_new_block(TS_RANDOM, (blk == 0) ? 5 : $urandom_range(2, 5));
			repeat ($urandom_range(5, 25))
				if (enc_total < OUT_GOAL)
					enc_code(K_RANDOM);
		end

		ending = $urandom_range(END_CLEAN, END_LEN);
		mark_last = 1;
		case (ending)
			END_CLEAN: begin
				enc_bits(9'h1FF, 9);
				comp_bytes.push_back(8'd0);
			end
			END_TRAIL: begin
				enc_bits(9'h1FF, 9);
				// A set bit after the end code, or an end that was never marked last.
				if (bits_free > 0 && $urandom_range(0, 1))
					comp_bytes[bit_at][bits_free - 1] = 1'b1;
				else
					mark_last = 0;
				comp_bytes.push_back(8'd0);
			end
			END_TRUNC: begin
				// Cut the stream short and mark its new last byte.
				repeat ($urandom_range(1, 3))
					void'(comp_bytes.pop_back());
			end
			END_OFFS: begin
				// Three-byte match whose offset equals the bytes written so far.
				enc_new_block(TS_ERROR, 2);
				enc_bits(2'b10, 2);
				enc_bits(2, 2);
				enc_bits(1, 2);
				enc_bits(enc_total, 15);
			end
			default: begin
				// Third length slot at its top value: length 65540.
				enc_new_block(TS_ERROR, 2);
				enc_bits(4'b1110, 4);
				enc_bits(15'h7FFF, 15);
			end
		endcase

		idx = 0;
		while (dec_err == ST_OK && dec_ph != PH_DONE) begin
			if (dec_out_full) begin
				if ($urandom_range(0, 9) == 0)
					add_word(0, $urandom_range(0, 255), $urandom_range(0, 1));
				else
					add_word(1, $urandom_range(0, 255), $urandom_range(0, 1));
			end else if (idx < comp_bytes.size()) begin
				if ($urandom_range(0, 9) == 0) begin
					add_word(1, $urandom_range(0, 255), $urandom_range(0, 1));
				end else begin
					add_word(0, comp_bytes[idx], mark_last && idx == comp_bytes.size() - 1);
					idx++;
				end
			end else begin
				break;
			end
		end
		// A few words after the end, which only repeat the final state.
		repeat ($urandom_range(3, 6))
			add_word($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1));
		n_words = word_q.size();
	endtask

	// ------------------------------------------------------------------
	// Sender: a new word goes out at the falling edge once the previous one
	// was taken. Gaps come in bursts, except near the end of the run.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : sender
		word_t w;
		if (!in_valid || took) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (go && word_q.size() > 0) begin
				if (word_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else begin
					w = word_q.pop_front();
					cur_res <= word_res_q.pop_front();
					mode <= w.mode;
					in_byte <= w.data;
					in_last <= w.last;
					in_valid <= 1'b1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, and once a long hold so that the
	// block fills up and stalls its input while words keep being offered.
	always @(negedge clk) begin : receiver
		if (recv_hold > 0) begin
			recv_hold--;
			res_stall <= 1'b1;
		end else if (!pressed && n_taken >= 120) begin
			pressed = 1;
			recv_hold = 300;
			res_stall <= 1'b1;
		end else if (word_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
			recv_hold = $urandom_range(0, 13);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	function automatic void check_field(string nm, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
			errors++;
		end
	endfunction

	// At the rising edge: note accepted words, check results, watch the clock count.
	always @(posedge clk) begin : monitor
		res_t want;
		cycles++;
		took <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			due_q.push_back(cur_res);
			n_taken++;
		end
		if (res_valid && !res_stall) begin
			if (due_q.size() == 0) begin
				$display("%0t: result word with none expected, actual ov=%0b byte=%0h st=%0d",
					$time, out_valid, out_byte, status);
				errors++;
			end else begin
				want = due_q.pop_front();
				check_field("out_valid", want.ov, out_valid);
				check_field("out_byte", want.ob, out_byte);
				check_field("need_byte", want.nb, need_byte);
				check_field("finished", want.fin, finished);
				check_field("status", want.st, status);
			end
		end
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		go = 1;
		while (n_taken < n_words)
			@(posedge clk);
		while (due_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ lz_bitstream_decompressor.f @@
sv/lzd_pkg.sv
sv/lzd_ram.sv
sv/lz_bitstream_decompressor.sv
test/lz_bitstream_decompressor_tb.sv
